@@ rtl/assert_macros.svh @@
// Shared assertion macros for the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/mbr_pkg.sv @@
package mbr_pkg;

  localparam int SLOT_COUNT = 4;      // primary slots reported, 1..4
  localparam int TABLE_SLOTS = 4;     // slots the table holds
  localparam int OFF_W = 9;

  localparam logic [OFF_W-1:0] TABLE_BASE = 9'd446;
  localparam int ENTRY_SIZE = 16;
  localparam logic [OFF_W-1:0] TABLE_END = OFF_W'(446 + TABLE_SLOTS * ENTRY_SIZE);
  localparam logic [OFF_W-1:0] SIG_LOW_OFFSET = 9'd510;
  localparam logic [OFF_W-1:0] SIG_HIGH_OFFSET = 9'd511;

  localparam logic [7:0] SIG_LOW_VALUE = 8'h55;
  localparam logic [7:0] SIG_HIGH_VALUE = 8'hAA;
  localparam logic [7:0] TYPE_EMPTY = 8'h00;
  localparam logic [7:0] TYPE_EXT_CHS = 8'h05;
  localparam logic [7:0] TYPE_EXT_LBA = 8'h0F;

  // byte positions inside one 16-byte entry
  localparam logic [3:0] FLD_TYPE = 4'd4;
  localparam logic [3:0] FLD_START_LO = 4'd8;
  localparam logic [3:0] FLD_START_HI = 4'd11;
  localparam logic [3:0] FLD_LEN_LO = 4'd12;

  // register index carried in paddr[2]
  localparam logic REG_DISK_TOTAL = 1'b0;

  typedef struct packed {
    logic [7:0]  ptype;
    logic [31:0] start;
    logic [31:0] length;
  } entry_t;

  typedef struct packed {
    logic go;       // byte 511 was taken last cycle
    logic sig_ok;
  } eval_req_t;

endpackage

@@ rtl/mbr_if.sv @@
interface mbr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       sector_start;

  modport source (output valid, output data_byte, output sector_start, input ready);
  modport sink (input valid, input data_byte, input sector_start, output ready);
endinterface

interface mbr_rec_if;
  logic        valid;
  logic        ready;
  logic        record_valid;
  logic [2:0]  slot_number;
  logic [7:0]  partition_type;
  logic [31:0] start_lba;
  logic [31:0] length_sectors;
  logic        signature_ok;
  logic [2:0]  accepted_count;
  logic        last_record;

  modport source (
    output valid, output record_valid, output slot_number, output partition_type,
    output start_lba, output length_sectors, output signature_ok,
    output accepted_count, output last_record, input ready
  );
  modport sink (
    input valid, input record_valid, input slot_number, input partition_type,
    input start_lba, input length_sectors, input signature_ok,
    input accepted_count, input last_record, output ready
  );
endinterface

@@ rtl/mbr_partition_table_parser.sv @@
// MBR partition table parser. Feed the 512 bytes of a disk's first sector,
// one byte per input beat; a beat with sector_start set is byte 0, and the
// offset wraps after byte 511 so unmarked sectors parse the same way. The
// block accepts one byte every cycle, except that byte 511 may be held off.
// Taking byte 511 registers the 0x55 0xAA signature verdict; the queue then
// checks the four primary entries against disk_total (APB register at address
// 0) and emits one record beat per usable entry in slot order, one per cycle
// while the sink is ready; if the signature is bad or no entry is usable it
// emits a single summary beat instead. last_record marks the final beat of
// each sector. Records drain from a four-entry snapshot, so the following
// sector's bytes keep flowing while they go out; only byte 511 of the next
// sector is held off if the earlier records are still undelivered. There is
// no clearing pass after reset.
module mbr_partition_table_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  mbr_in_if.sink      byte_in,
  mbr_rec_if.source   rec_out
);
  import mbr_pkg::*;

  // Config register
  logic [31:0] disk_total;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DISK_TOTAL) ? disk_total : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_total <= 32'd0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_DISK_TOTAL)) begin
      disk_total <= pwdata;
    end
  end

  // Byte offset tracking
  logic [OFF_W-1:0] byte_offset;
  logic [OFF_W-1:0] off_now;
  logic             take;
  logic             busy;
  eval_req_t        eval_req;

  assign off_now = byte_in.sector_start ? '0 : byte_offset;

  // Byte 511 launches an evaluation, which needs an empty record buffer.
  assign byte_in.ready = !((off_now == SIG_HIGH_OFFSET) && (eval_req.go || busy));
  assign take = byte_in.valid && byte_in.ready;

  // Table capture: offsets 446..509 map to four 16-byte entries
  logic       in_table;
  logic [5:0] rel;
  logic [1:0] slot;
  logic [3:0] ent_pos;
  entry_t     entries [SLOT_COUNT];
  logic [7:0] sig_low;

  assign in_table = (off_now >= TABLE_BASE) && (off_now < TABLE_END);
  assign rel = 6'(off_now - TABLE_BASE);
  assign slot = rel[5:4];
  assign ent_pos = rel[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      sig_low <= 8'd0;
      eval_req.go <= 1'b0;
    end else begin
      eval_req.go <= take && (off_now == SIG_HIGH_OFFSET);
      if (take) begin
        byte_offset <= off_now + OFF_W'(1);
        if (off_now == SIG_LOW_OFFSET) begin
          sig_low <= byte_in.data_byte;
        end
      end
    end
    // signature verdict rides with the evaluation strobe
    eval_req.sig_ok <= (sig_low == SIG_LOW_VALUE) && (byte_in.data_byte == SIG_HIGH_VALUE);
  end

  // Entry stores: payload only, every byte is rewritten before byte 511
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (take && in_table && (slot == 2'(i))) begin
        if (ent_pos == FLD_TYPE) begin
          entries[i].ptype <= byte_in.data_byte;
        end else if ((ent_pos >= FLD_START_LO) && (ent_pos <= FLD_START_HI)) begin
          entries[i].start[8 * ent_pos[1:0] +: 8] <= byte_in.data_byte;
        end else if (ent_pos >= FLD_LEN_LO) begin
          entries[i].length[8 * ent_pos[1:0] +: 8] <= byte_in.data_byte;
        end
      end
    end
  end

  // Evaluation and record drain
  mbr_rec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .eval_req   (eval_req),
    .entries    (entries),
    .disk_total (disk_total),
    .busy       (busy),
    .rec_out    (rec_out)
  );

endmodule

@@ rtl/mbr_rec_queue.sv @@
module mbr_rec_queue (
  input  logic               clk,
  input  logic               rst,
  input  mbr_pkg::eval_req_t eval_req,
  input  mbr_pkg::entry_t    entries [mbr_pkg::SLOT_COUNT],
  input  logic [31:0]        disk_total,
  output logic               busy,
  mbr_rec_if.source          rec_out
);
  import mbr_pkg::*;

  logic [SLOT_COUNT-1:0] usable;
  logic [SLOT_COUNT-1:0] mask;
  logic [SLOT_COUNT-1:0] mask_rest;
  logic                  summary;
  logic                  sig_ok;
  logic [2:0]            count;
  logic [2:0]            count_next;
  entry_t                snap [SLOT_COUNT];
  logic                  pop;

  // bounds and type checks, one compare set per slot
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      usable[i] = (entries[i].ptype != TYPE_EMPTY) && (entries[i].length != 32'd0) &&
                  (entries[i].ptype != TYPE_EXT_CHS) && (entries[i].ptype != TYPE_EXT_LBA) &&
                  (entries[i].start < disk_total) &&
                  (entries[i].length <= disk_total - entries[i].start);
    end
  end

  always_comb begin
    count_next = 3'd0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      count_next = count_next + {2'b00, usable[i]};
    end
  end

  assign busy = (|mask) || summary;
  assign pop = rec_out.valid && rec_out.ready;
  assign mask_rest = mask & (mask - SLOT_COUNT'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      summary <= 1'b0;
    end else if (eval_req.go) begin
      mask <= eval_req.sig_ok ? usable : '0;
      summary <= !(eval_req.sig_ok && (|usable));
      sig_ok <= eval_req.sig_ok;
      count <= eval_req.sig_ok ? count_next : 3'd0;
      snap <= entries;
    end else if (pop) begin
      if (summary) begin
        summary <= 1'b0;
      end else begin
        mask <= mask_rest;
      end
    end
  end

  // lowest pending slot goes first
  always_comb begin
    rec_out.slot_number = 3'd0;
    rec_out.partition_type = 8'd0;
    rec_out.start_lba = 32'd0;
    rec_out.length_sectors = 32'd0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) begin
        rec_out.slot_number = 3'(i + 1);
        rec_out.partition_type = snap[i].ptype;
        rec_out.start_lba = snap[i].start;
        rec_out.length_sectors = snap[i].length;
      end
    end
  end

  assign rec_out.valid = busy;
  assign rec_out.record_valid = |mask;
  assign rec_out.signature_ok = sig_ok;
  assign rec_out.accepted_count = count;
  assign rec_out.last_record = summary || (mask_rest == '0);

endmodule

@@ rtl/mbr_checker.sv @@
`include "assert_macros.svh"

module mbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        record_valid,
  input logic [2:0]  slot_number,
  input logic [31:0] start_lba,
  input logic        signature_ok,
  input logic [2:0]  accepted_count,
  input logic        last_record
);

  // a stalled beat keeps its slot and start
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(slot_number) && $stable(start_lba))

  // the summary beat always closes a sector
  `ASSERT_SAME(a_summary_last, clk, rst, out_valid && !record_valid, last_record && (slot_number == 3'd0) && (accepted_count == 3'd0))

  // partition beats only after a good signature, with a real slot
  `ASSERT_SAME(a_record_fields, clk, rst, out_valid && record_valid, signature_ok && (slot_number != 3'd0) && (accepted_count != 3'd0))

  // a partition beat that is not last is followed by more beats
  `ASSERT_NEXT(a_more_follow, clk, rst, out_valid && out_ready && record_valid && !last_record, out_valid && record_valid)

endmodule

bind mbr_partition_table_parser mbr_checker u_mbr_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (rec_out.valid),
  .out_ready      (rec_out.ready),
  .record_valid   (rec_out.record_valid),
  .slot_number    (rec_out.slot_number),
  .start_lba      (rec_out.start_lba),
  .signature_ok   (rec_out.signature_ok),
  .accepted_count (rec_out.accepted_count),
  .last_record    (rec_out.last_record)
);

@@ tb/mbr_record_board_pkg.sv @@
package mbr_record_board_pkg;
  import mbr_pkg::*;

  // One record beat as seen on the output channel.
  typedef struct packed {
    logic        record_valid;
    logic [2:0]  slot_number;
    logic [7:0]  partition_type;
    logic [31:0] start_lba;
    logic [31:0] length_sectors;
    logic        signature_ok;
    logic [2:0]  accepted_count;
    logic        last_record;
  } mbr_record_t;

  // Tracks the sector being parsed and keeps the records it should produce.
  class mbr_record_board;
    logic [31:0]      disk_total;
    logic [OFF_W-1:0] byte_pos;
    logic [7:0]       sig_low;
    entry_t           entries [TABLE_SLOTS];
    mbr_record_t      pending [$];
    int               errors;
    int               checked;

    function new();
      disk_total = '0;
      byte_pos = '0;
      sig_low = '0;
      errors = 0;
      checked = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function bit fits(int slot);
      if (entries[slot].ptype == TYPE_EMPTY || entries[slot].length == 32'd0) return 1'b0;
      if (entries[slot].ptype == TYPE_EXT_CHS || entries[slot].ptype == TYPE_EXT_LBA)
        return 1'b0;
      return (entries[slot].start < disk_total) &&
             (entries[slot].length <= disk_total - entries[slot].start);
    endfunction

    // Accepted input beat: capture table bytes, queue records on byte 511.
    function void note_byte(input logic [7:0] b, input logic first);
      logic [OFF_W-1:0] off;
      logic [OFF_W-1:0] rel;
      int               slot;
      int               pos;
      int               hits;
      int               sent;
      bit               sig_good;
      mbr_record_t      rec;
      if (first) byte_pos = '0;
      off = byte_pos;
      byte_pos = off + 1'b1;
      if (off >= TABLE_BASE && off < TABLE_END) begin
        rel = off - TABLE_BASE;
        slot = int'(rel) / ENTRY_SIZE;
        pos = int'(rel) % ENTRY_SIZE;
        if (slot < SLOT_COUNT) begin
          if (pos == FLD_TYPE) begin
            entries[slot].ptype = b;
          end else if (pos >= FLD_START_LO && pos <= FLD_START_HI) begin
            entries[slot].start[8*(pos-FLD_START_LO) +: 8] = b;
          end else if (pos >= FLD_LEN_LO) begin
            entries[slot].length[8*(pos-FLD_LEN_LO) +: 8] = b;
          end
        end
      end
      if (off == SIG_LOW_OFFSET) sig_low = b;
      if (off != SIG_HIGH_OFFSET) return;

      sig_good = (sig_low == SIG_LOW_VALUE) && (b == SIG_HIGH_VALUE);
      hits = 0;
      if (sig_good) begin
        for (int s = 0; s < SLOT_COUNT; s++) if (fits(s)) hits++;
      end
      if (hits == 0) begin
        rec = '0;
        rec.signature_ok = sig_good;
        rec.last_record = 1'b1;
        pending.push_back(rec);
        return;
      end
      sent = 0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        if (fits(s)) begin
          sent++;
          rec.record_valid = 1'b1;
          rec.slot_number = 3'(s + 1);
          rec.partition_type = entries[s].ptype;
          rec.start_lba = entries[s].start;
          rec.length_sectors = entries[s].length;
          rec.signature_ok = 1'b1;
          rec.accepted_count = 3'(hits);
          rec.last_record = (sent == hits);
          pending.push_back(rec);
        end
      end
    endfunction

    function string show(input mbr_record_t r);
      return $sformatf("{ok %0b slot %0d type %02h start %08h len %08h sig %0b cnt %0d last %0b}",
                       r.record_valid, r.slot_number, r.partition_type, r.start_lba,
                       r.length_sectors, r.signature_ok, r.accepted_count, r.last_record);
    endfunction

    task report(input string what);
      errors++;
      $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // Accepted output beat: compare against the oldest queued record.
    task check_record(input mbr_record_t got);
      mbr_record_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("record %0d not expected: %s", checked, show(got)));
        return;
      end
      want = pending.pop_front();
      if (got !== want)
        report($sformatf("record %0d got %s want %s", checked, show(got), show(want)));
    endtask
  endclass

endpackage

@@ tb/mbr_partition_table_parser_test.sv @@
module mbr_partition_table_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbr_pkg::*;
  import mbr_record_board_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int SECTOR_BYTES = 512;
  localparam int STALL_LIMIT  = 10000;  // cycles with no beat on either channel
  localparam int DRAIN_CYCLES = 8;      // records start once the queue has latched byte 511's evaluation
  localparam int HOLD_CYCLES  = 1500;   // long sink hold-off, > one sector of bytes

  typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_e;

  // Flavors of one partition entry, judged against the current disk size.
  typedef enum {
    ENT_USABLE, ENT_EXACT, ENT_EMPTY, ENT_ZERO_LEN,
    ENT_EXTENDED, ENT_PAST_END, ENT_TOO_LONG, ENT_NOISE
  } entry_kind_e;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mbr_in_if  byte_if ();
  mbr_rec_if rec_if ();

  mbr_partition_table_parser i_dut (
    .clk,
    .rst,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .byte_in (byte_if.sink),
    .rec_out (rec_if.source)
  );

  always #(HALF_PERIOD) clk = ~clk;

  mbr_record_board board;
  mbr_record_t     rec_now;

  logic [7:0]  sector_img [SECTOR_BYTES];
  logic [31:0] disk_total_now = '0;   // disk size used to shape entries
  bit          need_mark = 1'b0;      // a cut sector leaves the offset mid-way
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          sink_hold_req = 0;     // nonzero: sink holds ready low this long
  int          stall_cycles = 0;

  assign rec_now = {rec_if.record_valid, rec_if.slot_number, rec_if.partition_type,
                    rec_if.start_lba, rec_if.length_sectors, rec_if.signature_ok,
                    rec_if.accepted_count, rec_if.last_record};

  // Monitor. Everything is sampled at the rising edge, before any NBA lands.
  // The output beat is checked first: a byte taken this edge can't have
  // produced a record at the same edge.
  always @(posedge clk) begin
    if (rec_if.valid && rec_if.ready) board.check_record(rec_now);
    if (byte_if.valid && byte_if.ready)
      board.note_byte(byte_if.data_byte, byte_if.sector_start);
    if (rst || (rec_if.valid && rec_if.ready) || (byte_if.valid && byte_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // Watchdog: nothing moved for too long.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // Sink side. Random stalls, plus a long hold-off on request that is
  // counted here so the sender keeps pushing the whole time.
  initial begin
    int hold;
    forever begin
      if (sink_hold_req != 0) begin
        hold = sink_hold_req;
        sink_hold_req = 0;
        rec_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        rec_if.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
        @(posedge clk);
      end
    end
  end

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      IDLE_SRC:  begin src_idle_pct = 71; sink_stall_pct = 0;  end
      IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 71; end
      default:   begin src_idle_pct = 29; sink_stall_pct = 29; end
    endcase
  endtask

  // One input beat. valid only drops when a gap is taken, so back-to-back
  // beats never see a low and a high NBA in the same step.
  task automatic push_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.sector_start <= first;
    do @(posedge clk); while (byte_if.ready !== 1'b1);
  endtask

  // Send the image, optionally marked with sector_start and optionally cut
  // short. A cut sector forces a mark on the next one.
  task automatic send_sector(input bit marked, input int cut);
    for (int i = 0; i < cut; i++) push_byte(sector_img[i], marked && (i == 0));
    need_mark = (cut != SECTOR_BYTES);
  endtask

  // Drop valid and wait until every queued record came back, then wait out
  // DRAIN_CYCLES so no evaluation is still in flight.
  task automatic settle();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_disk_total(input logic [31:0] total);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_DISK_TOTAL, 2'b00};
    pwdata <= total;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.disk_total = total;
    disk_total_now = total;
  endtask

  function automatic void fill_sector(input logic [7:0] pattern, input bit scramble);
    foreach (sector_img[i]) sector_img[i] = scramble ? 8'($urandom) : pattern;
  endfunction

  function automatic void put_signature(input logic [7:0] lo, input logic [7:0] hi);
    sector_img[SIG_LOW_OFFSET] = lo;
    sector_img[SIG_HIGH_OFFSET] = hi;
  endfunction

  // Write one 16-byte table entry: type byte plus little-endian start/count.
  function automatic void put_entry(input int slot, input logic [7:0] ptype,
                                    input logic [31:0] start, input logic [31:0] count);
    int base;
    base = int'(TABLE_BASE) + ENTRY_SIZE * slot;
    sector_img[base + FLD_TYPE] = ptype;
    for (int k = 0; k < 4; k++) begin
      sector_img[base + FLD_START_LO + k] = start[8*k +: 8];
      sector_img[base + FLD_LEN_LO + k] = count[8*k +: 8];
    end
  endfunction

  // Build an entry of the given flavor against the current disk size.
  function automatic void make_entry(input int slot, input entry_kind_e kind);
    logic [7:0]  ptype;
    logic [31:0] start;
    logic [31:0] count;
    logic [31:0] room;
    do ptype = 8'($urandom_range(255, 1));
    while (ptype == TYPE_EXT_CHS || ptype == TYPE_EXT_LBA);
    start = (disk_total_now == '0) ? 32'($urandom) : 32'($urandom) % disk_total_now;
    room = disk_total_now - start;
    count = (room == '0) ? 32'd1 : 32'd1 + 32'($urandom) % room;
    case (kind)
      ENT_EXACT:    count = room;
      ENT_EMPTY:    ptype = TYPE_EMPTY;
      ENT_ZERO_LEN: count = '0;
      ENT_EXTENDED: ptype = $urandom_range(1, 0) ? TYPE_EXT_CHS : TYPE_EXT_LBA;
      ENT_PAST_END: begin
        // start at or beyond the disk end; a zero-size disk rejects anything
        if (disk_total_now != '0)
          start = disk_total_now + 32'($urandom) % (~disk_total_now + 32'd1);
      end
      ENT_TOO_LONG: count = room + 32'd1;
      ENT_NOISE: begin
        ptype = 8'($urandom);
        start = 32'($urandom);
        count = 32'($urandom);
      end
      default: ;
    endcase
    put_entry(slot, ptype, start, count);
  endfunction

  // Mostly well-formed sectors with random entries; the rest bad
  // signatures, pure noise and sectors cut short by a fresh sector_start.
  task automatic random_sector();
    int          pick;
    int          cut;
    int          roll;
    entry_kind_e kind;
    pick = $urandom_range(99, 0);
    cut = SECTOR_BYTES;
    fill_sector(8'h00, 1'b1);
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      roll = $urandom_range(99, 0);
      if (roll < 45) kind = ENT_USABLE;
      else if (roll < 55) kind = ENT_EXACT;
      else kind = entry_kind_e'($urandom_range(int'(ENT_NOISE), int'(ENT_EMPTY)));
      make_entry(s, kind);
    end
    put_signature(SIG_LOW_VALUE, SIG_HIGH_VALUE);
    if (pick < 8) begin
      if ($urandom_range(1, 0)) put_signature(8'($urandom), SIG_HIGH_VALUE);
      else put_signature(SIG_LOW_VALUE, 8'($urandom));
    end else if (pick < 14) begin
      fill_sector(8'h00, 1'b1);
    end else if (pick < 20) begin
      cut = $urandom_range(SECTOR_BYTES - 1, 1);
    end
    send_sector(need_mark || ($urandom_range(99, 0) < 85), cut);
  endtask

  initial begin
    logic [31:0] total;
    board = new();
    byte_if.valid <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.sector_start <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst <= 1'b1;
    set_idle(IDLE_NONE);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed: disk of 2048 sectors ----
    write_disk_total(32'd2048);

    // four usable slots, two of them ending exactly at the disk end
    fill_sector(8'h00, 1'b0);
    put_entry(0, 8'h83, 32'd0, 32'd1024);
    put_entry(1, 8'hFF, 32'd1024, 32'd1000);
    put_entry(2, 8'h01, 32'd2047, 32'd1);
    put_entry(3, 8'h07, 32'd2024, 32'd24);
    put_signature(SIG_LOW_VALUE, SIG_HIGH_VALUE);
    send_sector(1'b1, SECTOR_BYTES);

    // bad high signature byte, then bad low byte: summary only
    put_signature(SIG_LOW_VALUE, 8'hAB);
    send_sector(1'b1, SECTOR_BYTES);
    put_signature(8'h54, SIG_HIGH_VALUE);
    send_sector(1'b1, SECTOR_BYTES);

    // same table unmarked: offset wraps after byte 511
    put_signature(SIG_LOW_VALUE, SIG_HIGH_VALUE);
    send_sector(1'b0, SECTOR_BYTES);

    // sector cut inside the table, restarted by a fresh sector_start
    send_sector(1'b1, 470);
    send_sector(1'b1, SECTOR_BYTES);

    // empty, zero count, both extended types: good signature, nothing usable
    fill_sector(8'hFF, 1'b0);
    put_entry(0, TYPE_EMPTY, 32'd0, 32'd10);
    put_entry(1, 8'h83, 32'd0, 32'd0);
    put_entry(2, TYPE_EXT_CHS, 32'd0, 32'd10);
    put_entry(3, TYPE_EXT_LBA, 32'd0, 32'd10);
    put_signature(SIG_LOW_VALUE, SIG_HIGH_VALUE);
    send_sector(1'b1, SECTOR_BYTES);

    // range edges: start at end, one too long, exact fit, all-ones entry
    put_entry(0, 8'h83, 32'd2048, 32'd1);
    put_entry(1, 8'h83, 32'd100, 32'd1949);
    put_entry(2, 8'h0C, 32'd100, 32'd1948);
    put_entry(3, 8'h83, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sector(1'b1, SECTOR_BYTES);

    // ---- zero-size disk rejects every entry ----
    settle();
    write_disk_total(32'd0);
    fill_sector(8'h00, 1'b1);
    put_entry(0, 8'h83, 32'd0, 32'd1);
    put_entry(1, 8'h07, 32'd0, 32'hFFFF_FFFF);
    put_entry(2, 8'h0B, 32'd5, 32'd5);
    put_entry(3, 8'hFF, 32'hFFFF_FFFF, 32'd1);
    put_signature(SIG_LOW_VALUE, SIG_HIGH_VALUE);
    send_sector(1'b1, SECTOR_BYTES);

    // ---- largest disk: unsigned overflow in the range check ----
    settle();
    write_disk_total(32'hFFFF_FFFF);
    put_entry(0, 8'h83, 32'hFFFF_FFFE, 32'd1);
    put_entry(1, 8'h83, 32'hFFFF_FFFF, 32'd1);
    put_entry(2, 8'h83, 32'd0, 32'hFFFF_FFFF);
    put_entry(3, 8'h83, 32'd1, 32'hFFFF_FFFF);
    send_sector(1'b1, SECTOR_BYTES);

    // ---- random: every idle mode, two disk sizes each ----
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 2; k++) begin
        case ((2*m + k) % 4)
          0:       total = $urandom_range(5000, 1);
          1:       total = 32'hFFFF_FFFF;
          2:       total = $urandom;
          default: total = $urandom_range(64, 1);
        endcase
        settle();
        write_disk_total(total);
        set_idle(idle_mode_e'(m));
        repeat (5) random_sector();
      end
    end

    // ---- back-pressure: sink holds off while full sectors keep coming,
    // so the record snapshot fills and byte 511 of the next sector waits ----
    settle();
    write_disk_total($urandom_range(100000, 1000));
    set_idle(IDLE_NONE);
    sink_hold_req = HOLD_CYCLES;
    repeat (3) begin
      fill_sector(8'h00, 1'b1);
      for (int s = 0; s < TABLE_SLOTS; s++) make_entry(s, ENT_USABLE);
      put_signature(SIG_LOW_VALUE, SIG_HIGH_VALUE);
      send_sector(1'b1, SECTOR_BYTES);
    end

    settle();
    if (board.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
